FILE: hw/rtl/bpdc_pkg.sv
package bpdc_pkg;

  localparam int unsigned ButtonIndexW      = 3;
  localparam int unsigned TimeW             = 32;
  localparam int unsigned EventW            = 3;
  localparam int unsigned CfgIdxW           = 1;
  localparam int unsigned NumButtonsDefault = 7;

  localparam logic [TimeW-1:0] ShortPressResetMs = 32'd25;
  localparam logic [TimeW-1:0] LongPressResetMs  = 32'd1000;

  localparam logic [CfgIdxW-1:0] CfgShortPressMs = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPressMs  = 1'd1;

  localparam logic [EventW-1:0] EvIdle      = 3'd0;
  localparam logic [EventW-1:0] EvPending   = 3'd1;
  localparam logic [EventW-1:0] EvShortHeld = 3'd2;
  localparam logic [EventW-1:0] EvLongHeld  = 3'd3;
  localparam logic [EventW-1:0] EvShortRel  = 3'd4;
  localparam logic [EventW-1:0] EvLongRel   = 3'd5;

  typedef enum logic [5:0] {
    StIdle      = 6'b000001,
    StPending   = 6'b000010,
    StShortHeld = 6'b000100,
    StLongHeld  = 6'b001000,
    StShortRel  = 6'b010000,
    StLongRel   = 6'b100000
  } press_state_e;

  typedef struct packed {
    press_state_e next_state;
    logic         load_start;
  } fsm_out_t;

  function automatic logic [EventW-1:0] state_to_event(press_state_e st);
    logic [EventW-1:0] ev;
    unique case (st)
      StIdle:      ev = EvIdle;
      StPending:   ev = EvPending;
      StShortHeld: ev = EvShortHeld;
      StLongHeld:  ev = EvLongHeld;
      StShortRel:  ev = EvShortRel;
      StLongRel:   ev = EvLongRel;
      default:     ev = EvIdle;
    endcase
    return ev;
  endfunction

endpackage

FILE: hw/rtl/bpdc_fsm.sv
module bpdc_fsm import bpdc_pkg::*; (
  input  press_state_e     state_i,
  input  logic             pressed_i,
  input  logic [TimeW-1:0] elapsed_i,
  input  logic [TimeW-1:0] short_ms_i,
  input  logic [TimeW-1:0] long_ms_i,
  output fsm_out_t         fsm_o
);

  always_comb begin
    fsm_o.next_state = state_i;
    fsm_o.load_start = 1'b0;
    unique case (state_i)
      StIdle: begin
        if (pressed_i) begin
          fsm_o.next_state = StPending;
          fsm_o.load_start = 1'b1;
        end
      end
      StPending: begin
        if (!pressed_i) begin
          fsm_o.next_state = StIdle;
        end else if (elapsed_i >= short_ms_i) begin
          fsm_o.next_state = StShortHeld;
        end
      end
      StShortHeld: begin
        if (!pressed_i) begin
          fsm_o.next_state = StShortRel;
        end else if (elapsed_i >= long_ms_i) begin
          fsm_o.next_state = StLongHeld;
        end
      end
      StLongHeld: begin
        if (!pressed_i) begin
          fsm_o.next_state = StLongRel;
        end
      end
      default: fsm_o.next_state = StIdle;
    endcase
  end

endmodule

FILE: hw/rtl/button_press_duration_classifier_core.sv
// Short/long button press classifier. Each request polls one button with its raw
// active-low pin level and a millisecond timestamp; the block returns the button's
// new state (idle, pending, short held, long held, short released, long released).
// Timing: one request per cycle while the result is not stalled; a request is held
// in the input register, where a single subtract, compare and state update produce
// the result that is loaded into the output register and presented. A stalled
// result holds the input register, which then stalls the input. Thresholds must
// be written through the config port only while idle; the block does not enforce it.
module button_press_duration_classifier_core import bpdc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [TimeW-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ButtonIndexW-1:0] button_index_i,
  input  logic                    pin_level_i,
  input  logic [TimeW-1:0]        now_ms_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ButtonIndexW-1:0] button_number_o,
  output logic [EventW-1:0]       press_event_o
);

  localparam int unsigned IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [TimeW-1:0] short_ms_q, long_ms_q;

  logic                    in_vld_q, in_vld_d;
  logic [ButtonIndexW-1:0] in_idx_q;
  logic                    in_pin_q;
  logic [TimeW-1:0]        in_now_q;

  logic                    out_vld_q, out_vld_d;
  logic [ButtonIndexW-1:0] out_btn_q;
  logic [EventW-1:0]       out_evt_q;

  press_state_e     state_q [NUM_BUTTONS];
  logic [TimeW-1:0] start_q [NUM_BUTTONS];

  logic                           advance, in_accept, in_range;
  logic [IdxW+ButtonIndexW-1:0]   idx_ext;
  logic [IdxW-1:0]                sel;
  press_state_e                   cur_state;
  logic [TimeW-1:0]               elapsed;
  fsm_out_t                       fsm;
  logic [EventW-1:0]              evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ms_q <= ShortPressResetMs;
      long_ms_q  <= LongPressResetMs;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShortPressMs: short_ms_q <= cfg_wdata_i;
        CfgLongPressMs:  long_ms_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_idx_q <= button_index_i;
      in_pin_q <= pin_level_i;
      in_now_q <= now_ms_i;
    end
  end

  assign idx_ext   = {{IdxW{1'b0}}, in_idx_q};
  assign sel       = idx_ext[IdxW-1:0];
  assign in_range  = 32'(in_idx_q) < NUM_BUTTONS;
  assign cur_state = state_q[sel];
  assign elapsed   = in_now_q - start_q[sel];

  bpdc_fsm u_fsm (
    .state_i    (cur_state),
    .pressed_i  (!in_pin_q),
    .elapsed_i  (elapsed),
    .short_ms_i (short_ms_q),
    .long_ms_i  (long_ms_q),
    .fsm_o      (fsm)
  );

  assign evt = in_range ? state_to_event(fsm.next_state) : EvIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        state_q[i] <= StIdle;
        start_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (sel == IdxW'(i)) begin
          state_q[i] <= fsm.next_state;
          if (fsm.load_start) begin
            start_q[i] <= in_now_q;
          end
        end
      end
    end
  end

  assign out_vld_d = advance || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_btn_q <= in_idx_q;
      out_evt_q <= evt;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign button_number_o = out_btn_q;
  assign press_event_o   = out_evt_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_echo_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && button_number_o == $past(in_idx_q)))
    else $error("result does not echo button");

  a_out_of_range_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_range) |=> press_event_o == EvIdle)
    else $error("out-of-range poll not idle");

  a_release_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_range && (cur_state == StShortRel || cur_state == StLongRel))
    |=> press_event_o == EvIdle)
    else $error("released state did not return to idle");
`endif

endmodule

FILE: sim/bpdc_press_checker.sv
`timescale 1ns / 1ps

module bpdc_press_checker import bpdc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [TimeW-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [ButtonIndexW-1:0] button_index_i,
  input  logic                    pin_level_i,
  input  logic [TimeW-1:0]        now_ms_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [ButtonIndexW-1:0] button_number_i,
  input  logic [EventW-1:0]       press_event_i,
  output int                      mismatch_cnt_o,
  output int                      pending_cnt_o
);

  typedef struct packed {
    logic [ButtonIndexW-1:0] button;
    logic [EventW-1:0]       press_event;
  } press_result_t;

  logic [TimeW-1:0]  short_ms;
  logic [TimeW-1:0]  long_ms;
  logic [EventW-1:0] btn_state [NumButtonsDefault];
  logic [TimeW-1:0]  btn_start [NumButtonsDefault];
  press_result_t     expected_events_q [$];

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt_o < 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatch_cnt_o++;
  endtask

  function automatic logic [EventW-1:0] advance_button(input logic [ButtonIndexW-1:0] idx,
                                                       input logic pin,
                                                       input logic [TimeW-1:0] now);
    logic [EventW-1:0] st;
    logic [TimeW-1:0]  held_ms;
    logic              pressed;
    if (idx >= NumButtonsDefault) begin
      return EvIdle;
    end
    pressed = !pin;
    st = btn_state[idx];
    held_ms = now - btn_start[idx];
    case (st)
      EvIdle: begin
        if (pressed) begin
          st = EvPending;
          btn_start[idx] = now;
        end
      end
      EvPending: begin
        if (!pressed) begin
          st = EvIdle;
        end else if (held_ms >= short_ms) begin
          st = EvShortHeld;
        end
      end
      EvShortHeld: begin
        if (!pressed) begin
          st = EvShortRel;
        end else if (held_ms >= long_ms) begin
          st = EvLongHeld;
        end
      end
      EvLongHeld: begin
        if (!pressed) begin
          st = EvLongRel;
        end
      end
      default: st = EvIdle;
    endcase
    btn_state[idx] = st;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    press_result_t want;
    press_result_t fresh;
    if (!rst_ni) begin
      short_ms = ShortPressResetMs;
      long_ms = LongPressResetMs;
      for (int i = 0; i < NumButtonsDefault; i++) begin
        btn_state[i] = EvIdle;
        btn_start[i] = '0;
      end
      expected_events_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: button %0d event %0d",
                                    button_number_i, press_event_i));
        end else begin
          want = expected_events_q.pop_front();
          if (button_number_i !== want.button) begin
            report_mismatch($sformatf("button_number %0d, want %0d",
                                      button_number_i, want.button));
          end
          if (press_event_i !== want.press_event) begin
            report_mismatch($sformatf("press_event %0d, want %0d (button %0d)",
                                      press_event_i, want.press_event, want.button));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgShortPressMs) begin
          short_ms = cfg_wdata_i;
        end else if (cfg_idx_i == CfgLongPressMs) begin
          long_ms = cfg_wdata_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fresh.button = button_index_i;
        fresh.press_event = advance_button(button_index_i, pin_level_i, now_ms_i);
        expected_events_q.push_back(fresh);
      end
      pending_cnt_o <= expected_events_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb import bpdc_pkg::*;;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CfgIdxW-1:0]      cfg_idx;
  logic [TimeW-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [ButtonIndexW-1:0] button_index;
  logic                    pin_level;
  logic [TimeW-1:0]        now_ms;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ButtonIndexW-1:0] button_number;
  logic [EventW-1:0]       press_event;
  int                      mismatch_cnt;
  int                      pending_cnt;

  int               send_idle_pct = 0;
  int               stall_pct = 0;
  logic             hold_trigger = 1'b0;
  logic             long_hold = 1'b0;
  logic [TimeW-1:0] long_cfg = LongPressResetMs;
  logic [TimeW-1:0] clock_ms;
  bit               held [8];

  button_press_duration_classifier_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .button_index_i (button_index),
    .pin_level_i    (pin_level),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .button_number_o(button_number),
    .press_event_o  (press_event)
  );

  bpdc_press_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .button_index_i (button_index),
    .pin_level_i    (pin_level),
    .now_ms_i       (now_ms),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .button_number_i(button_number),
    .press_event_i  (press_event),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (hold_trigger);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (120) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_poll(input logic [ButtonIndexW-1:0] idx, input logic pin,
                           input logic [TimeW-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_index <= idx;
    pin_level <= pin;
    now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_thresholds(input logic [TimeW-1:0] short_val,
                                 input logic [TimeW-1:0] long_val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CfgShortPressMs;
    cfg_wdata <= short_val;
    @(posedge clk);
    cfg_idx <= CfgLongPressMs;
    cfg_wdata <= long_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    long_cfg = long_val;
  endtask

  // mostly ordered press/hold/release sequences, some out-of-range buttons and wild timestamps
  task automatic random_poll;
    logic [ButtonIndexW-1:0] idx;
    logic [TimeW-1:0]        now;
    int unsigned             span;
    idx = ($urandom_range(0, 11) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    if ($urandom_range(0, 15) == 0) begin
      now = $urandom;
    end else begin
      span = (long_cfg > 0 && long_cfg < 32'd5000) ? long_cfg / 8 + 2 : 40;
      clock_ms += $urandom_range(0, span);
      now = clock_ms;
    end
    if ($urandom_range(0, 4) == 0) begin
      held[idx] = !held[idx];
    end
    send_poll(idx, !held[idx], now);
  endtask

  initial begin
    logic [TimeW-1:0] phase_short [5];
    logic [TimeW-1:0] phase_long [5];
    int               phase_idle [5];
    int               phase_stall [5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgShortPressMs;
    cfg_wdata = '0;
    in_valid = 1'b0;
    button_index = '0;
    pin_level = 1'b1;
    now_ms = '0;
    phase_short = '{32'd25, 32'd0, 32'd5, 32'd200, 32'hFFFF_FFFF};
    phase_long = '{32'd1000, 32'd0, 32'd60, 32'd50, 32'hFFFF_FFFF};
    phase_idle = '{0, 46, 0, 34, 0};
    phase_stall = '{0, 0, 46, 34, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: full short/long cycle, wrap, late polls into long hold
    send_poll(3'd7, 1'b0, 32'd0);
    send_poll(3'd0, 1'b0, 32'd100);
    send_poll(3'd0, 1'b0, 32'd124);
    send_poll(3'd0, 1'b0, 32'd125);
    send_poll(3'd0, 1'b0, 32'd1099);
    send_poll(3'd0, 1'b0, 32'd1100);
    send_poll(3'd0, 1'b1, 32'd1200);
    send_poll(3'd0, 1'b0, 32'd1201);
    send_poll(3'd1, 1'b0, 32'd0);
    send_poll(3'd1, 1'b1, 32'd10);
    send_poll(3'd2, 1'b0, 32'hFFFF_FFF0);
    send_poll(3'd2, 1'b0, 32'h0000_0009);
    send_poll(3'd2, 1'b1, 32'h0000_000A);
    send_poll(3'd2, 1'b1, 32'h0000_000B);
    send_poll(3'd3, 1'b0, 32'd2000);
    send_poll(3'd3, 1'b0, 32'd5000);
    send_poll(3'd3, 1'b0, 32'd5000);

    load_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_poll(3'd4, 1'b0, 32'd5);
    send_poll(3'd4, 1'b0, 32'd4);
    send_poll(3'd4, 1'b0, 32'd4);
    send_poll(3'd4, 1'b1, 32'd4);

    load_thresholds(32'd0, 32'd0);
    send_poll(3'd6, 1'b0, 32'hFFFF_FFFF);
    send_poll(3'd6, 1'b0, 32'hFFFF_FFFF);
    send_poll(3'd6, 1'b0, 32'd0);
    send_poll(3'd5, 1'b1, 32'd7);

    clock_ms = $urandom;
    for (int p = 0; p < 5; p++) begin
      load_thresholds(phase_short[p], phase_long[p]);
      send_idle_pct = phase_idle[p];
      stall_pct <= phase_stall[p];
      for (int n = 0; n < 80; n++) begin
        if (p == 0 && n == 20) begin
          hold_trigger = 1'b1;
        end
        random_poll();
      end
    end

    in_valid <= 1'b0;
    for (int c = 0; c < 20000 && pending_cnt != 0; c++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
